// ----- rtl/core/bezier_curve_point_eval_top_defines.svh -----
// Assertion macros used by the Bezier evaluator checker
`ifndef BEZIER_CURVE_POINT_EVAL_TOP_DEFINES_SVH
`define BEZIER_CURVE_POINT_EVAL_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define BCPE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bcpe assertion failed");

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define BCPE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bcpe assertion failed");

`endif

// ----- rtl/core/bcpe_pkg.sv -----
// Types, constants and microcode program of the Bezier curve evaluator
package bcpe_pkg;

  localparam int MAX_DEGREE = 10;
  localparam int DEPTH      = MAX_DEGREE + 1;
  localparam int NCOORD     = 2;

  localparam int DEG_W   = 4;
  localparam int IDX_W   = 4;
  localparam int COORD_W = 16;
  localparam int T_W     = 17;
  localparam int FRAC_W  = 16;
  localparam int WORK_W  = COORD_W + FRAC_W;
  localparam int DIFF_W  = WORK_W + 1;
  localparam int PROD_W  = DIFF_W + T_W + 1;
  localparam int ACC_W   = PROD_W + 1;
  localparam int HALF_LSB = 32768;

  typedef logic [DEG_W-1:0]   deg_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [T_W-1:0]     param_t;
  typedef logic [WORK_W-1:0]  work_t;

  localparam deg_t   DEGREE_RST = 4'd3;
  localparam deg_t   DEG_MAX    = DEG_W'(MAX_DEGREE);
  localparam deg_t   DEG_ONE    = 4'd1;
  localparam param_t T_ONE      = 17'h10000;
  localparam coord_t SIGN_FLIP  = 16'h8000;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_EVAL  = 1'b1;

  typedef enum logic [1:0] {
    OP_IDLE,
    OP_LOAD,
    OP_INTERP,
    OP_OUT
  } op_e;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_NO_EVAL,
    COND_MORE,
    COND_OUT_BUSY
  } cond_e;

  localparam int PC_W        = 2;
  localparam int UCODE_DEPTH = 4;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_WAIT   = 2'd0;
  localparam pc_t PC_LOAD   = 2'd1;
  localparam pc_t PC_INTERP = 2'd2;
  localparam pc_t PC_FINISH = 2'd3;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } ucode_t;

  // jump to target when the condition holds, else step on (wrapping to the wait step)
  localparam ucode_t UCODE [UCODE_DEPTH] = '{
    '{op: OP_IDLE,   cond: COND_NO_EVAL,  target: PC_WAIT},
    '{op: OP_LOAD,   cond: COND_NEVER,    target: PC_WAIT},
    '{op: OP_INTERP, cond: COND_MORE,     target: PC_INTERP},
    '{op: OP_OUT,    cond: COND_OUT_BUSY, target: PC_FINISH}
  };

  typedef struct packed {
    op_e  op;
    deg_t round;
    logic last;
  } ctrl_t;

endpackage

// ----- rtl/core/bcpe_in_if.sv -----
// Input channel: control point writes and evaluate requests
interface bcpe_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic        [bcpe_pkg::IDX_W-1:0]   point_index;
  logic signed [bcpe_pkg::COORD_W-1:0] point_x;
  logic signed [bcpe_pkg::COORD_W-1:0] point_y;
  logic        [bcpe_pkg::T_W-1:0]     curve_param;

  modport source (output valid, kind, point_index, point_x, point_y, curve_param,
                  input ready);
  modport sink   (input valid, kind, point_index, point_x, point_y, curve_param,
                  output ready);
endinterface

// ----- rtl/core/bcpe_out_if.sv -----
// Output channel: evaluated curve points
interface bcpe_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [bcpe_pkg::COORD_W-1:0] curve_x;
  logic signed [bcpe_pkg::COORD_W-1:0] curve_y;

  modport source (output valid, curve_x, curve_y, input ready);
  modport sink   (input valid, curve_x, curve_y, output ready);
endinterface

// ----- rtl/core/bcpe_seq.sv -----
// Microcoded sequencer: program counter, round and step counters
module bcpe_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             eval_start_i,
  input  logic             out_busy_i,
  input  bcpe_pkg::deg_t   degree_i,
  output bcpe_pkg::ctrl_t  ctrl_o
);

  bcpe_pkg::pc_t    pc_q, pc_d;
  bcpe_pkg::deg_t   round_q, round_d;
  bcpe_pkg::deg_t   rem_q, rem_d;
  bcpe_pkg::ucode_t word;
  logic             jump;
  logic             last;

  assign word = bcpe_pkg::UCODE[pc_q];
  assign last = (rem_q == bcpe_pkg::DEG_ONE);

  always_comb begin
    case (word.cond)
      bcpe_pkg::COND_NEVER:    jump = 1'b0;
      bcpe_pkg::COND_NO_EVAL:  jump = !eval_start_i;
      bcpe_pkg::COND_MORE:     jump = !(last && round_q == bcpe_pkg::DEG_ONE);
      bcpe_pkg::COND_OUT_BUSY: jump = out_busy_i;
      default:                 jump = 1'b0;
    endcase
  end

  assign pc_d = jump ? word.target : pc_q + bcpe_pkg::PC_W'(1);

  always_comb begin
    round_d = round_q;
    rem_d   = rem_q;
    case (word.op)
      bcpe_pkg::OP_LOAD: begin
        round_d = degree_i;
        rem_d   = degree_i;
      end
      bcpe_pkg::OP_INTERP: begin
        if (last) begin
          round_d = round_q - bcpe_pkg::DEG_ONE;
          rem_d   = round_q - bcpe_pkg::DEG_ONE;
        end else begin
          rem_d   = rem_q - bcpe_pkg::DEG_ONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= bcpe_pkg::PC_WAIT;
      round_q <= bcpe_pkg::DEG_ONE;
      rem_q   <= bcpe_pkg::DEG_ONE;
    end else begin
      pc_q    <= pc_d;
      round_q <= round_d;
      rem_q   <= rem_d;
    end
  end

  assign ctrl_o.op    = word.op;
  assign ctrl_o.round = round_q;
  assign ctrl_o.last  = last;

endmodule

// ----- rtl/core/bcpe_dp.sv -----
// Datapath: control point store, de Casteljau work line and interpolation units
module bcpe_dp (
  input  logic                     clk_i,
  input  bcpe_pkg::ctrl_t          ctrl_i,
  input  logic                     wr_en_i,
  input  logic [bcpe_pkg::IDX_W-1:0] wr_idx_i,
  input  bcpe_pkg::coord_t         wr_pt_i [bcpe_pkg::NCOORD],
  input  logic                     eval_start_i,
  input  bcpe_pkg::param_t         param_i,
  output bcpe_pkg::coord_t         res_o [bcpe_pkg::NCOORD]
);

  bcpe_pkg::coord_t store_q [bcpe_pkg::NCOORD][bcpe_pkg::DEPTH];
  bcpe_pkg::work_t  work_q  [bcpe_pkg::NCOORD][bcpe_pkg::DEPTH];
  bcpe_pkg::work_t  work_d  [bcpe_pkg::NCOORD][bcpe_pkg::DEPTH];
  bcpe_pkg::work_t  nb1     [bcpe_pkg::NCOORD][bcpe_pkg::DEPTH];
  bcpe_pkg::work_t  nb2     [bcpe_pkg::NCOORD][bcpe_pkg::DEPTH];
  bcpe_pkg::work_t  lerp    [bcpe_pkg::NCOORD];
  bcpe_pkg::param_t t_q;
  bcpe_pkg::deg_t   round_m1;

  assign round_m1 = ctrl_i.round - bcpe_pkg::DEG_ONE;

  // saturate t to one on entry
  always_ff @(posedge clk_i) begin
    if (eval_start_i) begin
      t_q <= (param_i > bcpe_pkg::T_ONE) ? bcpe_pkg::T_ONE : param_i;
    end
  end

  for (genvar c = 0; c < bcpe_pkg::NCOORD; c++) begin : g_coord
    logic signed [bcpe_pkg::DIFF_W-1:0] diff;
    logic signed [bcpe_pkg::PROD_W-1:0] prod;
    logic signed [bcpe_pkg::ACC_W-1:0]  acc;
    logic        [bcpe_pkg::WORK_W:0]   rnd;

    // a*(1-t) + b*t == a + (b-a)*t
    assign diff = $signed({1'b0, work_q[c][1]}) - $signed({1'b0, work_q[c][0]});
    assign prod = diff * $signed({1'b0, t_q});
    assign acc  = $signed({{(bcpe_pkg::ACC_W - bcpe_pkg::WORK_W - bcpe_pkg::FRAC_W){1'b0}},
                           work_q[c][0], {bcpe_pkg::FRAC_W{1'b0}}})
                + bcpe_pkg::ACC_W'(prod) + bcpe_pkg::ACC_W'(bcpe_pkg::HALF_LSB);
    assign lerp[c] = acc[bcpe_pkg::FRAC_W + bcpe_pkg::WORK_W - 1:bcpe_pkg::FRAC_W];

    assign rnd = {1'b0, work_q[c][0]} + (bcpe_pkg::WORK_W + 1)'(bcpe_pkg::HALF_LSB);
    assign res_o[c] = rnd[bcpe_pkg::WORK_W-1:bcpe_pkg::FRAC_W] ^ bcpe_pkg::SIGN_FLIP;

    for (genvar k = 0; k < bcpe_pkg::DEPTH; k++) begin : g_slot
      if (k + 1 < bcpe_pkg::DEPTH) begin : g_nb1
        assign nb1[c][k] = work_q[c][k+1];
      end else begin : g_nb1_end
        assign nb1[c][k] = '0;
      end
      if (k + 2 < bcpe_pkg::DEPTH) begin : g_nb2
        assign nb2[c][k] = work_q[c][k+2];
      end else begin : g_nb2_end
        assign nb2[c][k] = '0;
      end

      always_ff @(posedge clk_i) begin
        if (wr_en_i && wr_idx_i == bcpe_pkg::IDX_W'(k)) begin
          store_q[c][k] <= wr_pt_i[c];
        end
      end

      // rotate the active points left, append the new point; the last step of a
      // round also drops the stale head
      always_comb begin
        work_d[c][k] = work_q[c][k];
        case (ctrl_i.op)
          bcpe_pkg::OP_LOAD: begin
            work_d[c][k] = {store_q[c][k] ^ bcpe_pkg::SIGN_FLIP, {bcpe_pkg::FRAC_W{1'b0}}};
          end
          bcpe_pkg::OP_INTERP: begin
            if (ctrl_i.last) begin
              if (bcpe_pkg::DEG_W'(k) == round_m1) begin
                work_d[c][k] = lerp[c];
              end else if (bcpe_pkg::DEG_W'(k) < round_m1) begin
                work_d[c][k] = nb2[c][k];
              end
            end else begin
              if (bcpe_pkg::DEG_W'(k) == ctrl_i.round) begin
                work_d[c][k] = lerp[c];
              end else if (bcpe_pkg::DEG_W'(k) < ctrl_i.round) begin
                work_d[c][k] = nb1[c][k];
              end
            end
          end
          default: begin
          end
        endcase
      end

      always_ff @(posedge clk_i) begin
        work_q[c][k] <= work_d[c][k];
      end
    end
  end

endmodule

// ----- rtl/core/bezier_curve_point_eval_top.sv -----
// Bezier curve point evaluator, top level
// Write beat: stored in the point store, no result; the next beat is taken in the following cycle.
// Evaluate beat: loads the points, runs n*(n+1)/2 interpolation steps, n the effective degree, then
// registers the result once the output register is free. Evaluations run one at a time on the shared
// interpolation unit. A finished result waits in the output register while the next beat is taken.
// Reset returns the sequencer to its wait step, clears output valid and sets degree to 3; point store is unset.
module bezier_curve_point_eval_top (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  bcpe_pkg::deg_t         cfg_wdata_i,
  bcpe_in_if.sink                in_i,
  bcpe_out_if.source             out_o
);

  bcpe_pkg::deg_t   degree_q;
  bcpe_pkg::deg_t   degree_eff;
  bcpe_pkg::ctrl_t  ctrl;
  bcpe_pkg::coord_t wr_pt [bcpe_pkg::NCOORD];
  bcpe_pkg::coord_t res   [bcpe_pkg::NCOORD];
  bcpe_pkg::coord_t curve_x_q, curve_y_q;
  logic             out_valid_q, out_valid_d;
  logic             in_ready;
  logic             eval_start;
  logic             wr_en;
  logic             out_busy;
  logic             out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= bcpe_pkg::DEGREE_RST;
    end else if (cfg_we_i) begin
      degree_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    degree_eff = degree_q;
    if (degree_q < bcpe_pkg::DEG_ONE) begin
      degree_eff = bcpe_pkg::DEG_ONE;
    end else if (degree_q > bcpe_pkg::DEG_MAX) begin
      degree_eff = bcpe_pkg::DEG_MAX;
    end
  end

  assign in_ready   = (ctrl.op == bcpe_pkg::OP_IDLE);
  assign in_i.ready = in_ready;
  assign eval_start = in_i.valid && in_ready && in_i.kind == bcpe_pkg::KIND_EVAL;
  assign wr_en      = in_i.valid && in_ready && in_i.kind == bcpe_pkg::KIND_WRITE;
  assign out_busy   = out_valid_q && !out_o.ready;
  assign out_load   = (ctrl.op == bcpe_pkg::OP_OUT) && !out_busy;

  assign wr_pt[0] = in_i.point_x;
  assign wr_pt[1] = in_i.point_y;

  bcpe_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .eval_start_i (eval_start),
    .out_busy_i   (out_busy),
    .degree_i     (degree_eff),
    .ctrl_o       (ctrl)
  );

  bcpe_dp u_dp (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .wr_en_i      (wr_en),
    .wr_idx_i     (in_i.point_index),
    .wr_pt_i      (wr_pt),
    .eval_start_i (eval_start),
    .param_i      (in_i.curve_param),
    .res_o        (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      curve_x_q <= res[0];
      curve_y_q <= res[1];
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.curve_x = curve_x_q;
  assign out_o.curve_y = curve_y_q;

endmodule

// ----- rtl/core/bcpe_checker.sv -----
// Port-level checker for the Bezier evaluator, bound to the top level
`include "bezier_curve_point_eval_top_defines.svh"

module bcpe_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   in_kind_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [bcpe_pkg::COORD_W-1:0] curve_x_i,
  input logic [bcpe_pkg::COORD_W-1:0] curve_y_i
);

  logic eval_beat;
  logic write_beat;

  assign eval_beat  = in_valid_i && in_ready_i && in_kind_i == bcpe_pkg::KIND_EVAL;
  assign write_beat = in_valid_i && in_ready_i && in_kind_i == bcpe_pkg::KIND_WRITE;

  `BCPE_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(curve_x_i) && $stable(curve_y_i))
  `BCPE_ASSERT_NXT(a_busy_after_eval, eval_beat, !in_ready_i)
  `BCPE_ASSERT_NXT(a_write_no_result, write_beat && !out_valid_i, !out_valid_i)
  `BCPE_ASSERT_IMP(a_ready_with_result, $rose(out_valid_i), in_ready_i)

endmodule

bind bezier_curve_point_eval_top bcpe_checker u_bcpe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_kind_i   (in_i.kind),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .curve_x_i   (out_o.curve_x),
  .curve_y_i   (out_o.curve_y)
);
